FILE: design/can_lrs_pkg.sv
// Shared types, constants and register codes of the CAN link recovery supervisor.
package can_lrs_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int TIME_W      = 32;
    localparam int FLAGS_W     = 8;
    localparam int POLL_W      = 16;
    localparam int SILENCE_W   = 22;
    localparam int THRESH_W    = 8;
    localparam int STEP_W      = 14;
    localparam int WAIT_W      = 14;
    localparam int RCOUNT_W    = 16;
    localparam int ACTION_W    = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 22;
    localparam int DIFF_W      = (COUNT_WIDTH + 1 > STEP_W) ? COUNT_WIDTH + 1 : STEP_W;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 40;

    localparam logic [FLAGS_W-1:0] FLAG_BUS_OFF  = 8'h20;
    localparam logic [FLAGS_W-1:0] FLAG_ERR_PASS = 8'h10;
    localparam logic [FLAGS_W-1:0] FLAG_OVERFLOW = 8'hC0;

    localparam logic [WAIT_W-1:0] BACKOFF_CAP = 14'd15000;
    localparam logic [WAIT_W-1:0] FAIL_WAIT   = 14'd500;
    localparam int                DECAY_SHIFT = 1;

    localparam logic [POLL_W-1:0]    POLL_PERIOD_RST = 16'd100;
    localparam logic [SILENCE_W-1:0] SILENCE_RST     = 22'd2000;
    localparam logic [THRESH_W-1:0]  THRESH_RST      = 8'd3;
    localparam logic [STEP_W-1:0]    STEP_RST        = 14'd1000;

    typedef enum logic [ACTION_W-1:0] {
        ACT_HEALTHY   = 3'd0,
        ACT_CLEAR_OVF = 3'd1,
        ACT_REINIT    = 3'd2,
        ACT_HELD_OFF  = 3'd3,
        ACT_RECOVERED = 3'd4,
        ACT_FAILED    = 3'd5
    } action_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_POLL_PERIOD = 2'd0,
        REG_SILENCE     = 2'd1,
        REG_THRESH      = 2'd2,
        REG_STEP        = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [POLL_W-1:0]    poll_interval_ms;
        logic [SILENCE_W-1:0] silence_timeout_ms;
        logic [THRESH_W-1:0]  resets_before_backoff;
        logic [STEP_W-1:0]    backoff_step_ms;
    } cfg_t;

    typedef struct packed {
        logic               mode;
        logic [TIME_W-1:0]  now_ms;
        logic [TIME_W-1:0]  last_rx_ms;
        logic [FLAGS_W-1:0] error_flags;
        logic               reinit_ok;
    } item_t;

    typedef struct packed {
        action_t             action;
        logic [WAIT_W-1:0]   wait_ms;
        logic [RCOUNT_W-1:0] reset_count;
        logic                bus_off;
        logic                error_passive;
        logic                rx_silent;
    } result_t;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] reset_counter;
        logic [TIME_W-1:0]      last_attempt_ms;
    } sup_state_t;

endpackage

FILE: design/can_lrs_decide.sv
// Per-word decision logic: classifies a poll or outcome and computes the next state.
module can_lrs_decide (
    input  can_lrs_pkg::item_t      item,
    input  can_lrs_pkg::cfg_t       cfg,
    input  can_lrs_pkg::sup_state_t state_cur,
    output can_lrs_pkg::sup_state_t state_next,
    output can_lrs_pkg::result_t    result
);

    logic [can_lrs_pkg::TIME_W-1:0]      age;
    logic [can_lrs_pkg::TIME_W-1:0]      since_attempt;
    logic [can_lrs_pkg::TIME_W-1:0]      timeout_ext;
    logic [can_lrs_pkg::TIME_W-1:0]      decay_lim;
    logic                                boff;
    logic                                epas;
    logic                                silent;
    logic                                overflow;
    logic                                held;
    logic [can_lrs_pkg::COUNT_WIDTH-1:0] cnt_inc;
    logic [can_lrs_pkg::DIFF_W-1:0]      diff;
    logic [can_lrs_pkg::STEP_W-1:0]      diff_clamp;
    logic [2*can_lrs_pkg::STEP_W-1:0]    product;
    logic [can_lrs_pkg::WAIT_W-1:0]      backoff;
    logic                                in_backoff;

    assign age           = item.now_ms - item.last_rx_ms;
    assign since_attempt = item.now_ms - state_cur.last_attempt_ms;
    assign timeout_ext   = can_lrs_pkg::TIME_W'(cfg.silence_timeout_ms);
    assign decay_lim     = timeout_ext >> can_lrs_pkg::DECAY_SHIFT;

    assign boff     = (item.error_flags & can_lrs_pkg::FLAG_BUS_OFF) != '0;
    assign epas     = (item.error_flags & can_lrs_pkg::FLAG_ERR_PASS) != '0;
    assign overflow = (item.error_flags & can_lrs_pkg::FLAG_OVERFLOW) != '0;
    assign silent   = (item.last_rx_ms != '0) ? (age > timeout_ext)
                                              : (item.now_ms > timeout_ext);
    assign held     = since_attempt < can_lrs_pkg::TIME_W'(cfg.poll_interval_ms);

    // saturating increment, then linear backoff with the cap
    assign cnt_inc    = (state_cur.reset_counter == '1) ? state_cur.reset_counter
                                                        : state_cur.reset_counter + 1'b1;
    assign in_backoff = can_lrs_pkg::DIFF_W'(cnt_inc)
                        >= can_lrs_pkg::DIFF_W'(cfg.resets_before_backoff);
    assign diff       = can_lrs_pkg::DIFF_W'(cnt_inc)
                        - can_lrs_pkg::DIFF_W'(cfg.resets_before_backoff)
                        + can_lrs_pkg::DIFF_W'(1);
    assign diff_clamp = (diff > can_lrs_pkg::DIFF_W'({can_lrs_pkg::STEP_W{1'b1}}))
                        ? '1 : diff[can_lrs_pkg::STEP_W-1:0];
    assign product    = (2*can_lrs_pkg::STEP_W)'(cfg.backoff_step_ms)
                        * (2*can_lrs_pkg::STEP_W)'(diff_clamp);
    assign backoff    = (product > (2*can_lrs_pkg::STEP_W)'(can_lrs_pkg::BACKOFF_CAP))
                        ? can_lrs_pkg::BACKOFF_CAP : product[can_lrs_pkg::WAIT_W-1:0];

    always_comb begin
        state_next           = state_cur;
        result.action        = can_lrs_pkg::ACT_HEALTHY;
        result.wait_ms       = '0;
        result.bus_off       = 1'b0;
        result.error_passive = 1'b0;
        result.rx_silent     = 1'b0;
        if (item.mode) begin
            if (item.reinit_ok) begin
                state_next.reset_counter = cnt_inc;
                result.action            = can_lrs_pkg::ACT_RECOVERED;
                result.wait_ms           = in_backoff ? backoff : '0;
            end else begin
                result.action  = can_lrs_pkg::ACT_FAILED;
                result.wait_ms = can_lrs_pkg::FAIL_WAIT;
            end
        end else begin
            result.bus_off       = boff;
            result.error_passive = epas;
            result.rx_silent     = silent;
            if (overflow) begin
                result.action = can_lrs_pkg::ACT_CLEAR_OVF;
            end else if (boff || epas || silent) begin
                if (held) begin
                    result.action = can_lrs_pkg::ACT_HELD_OFF;
                end else begin
                    result.action              = can_lrs_pkg::ACT_REINIT;
                    state_next.last_attempt_ms = item.now_ms;
                end
            end else begin
                if (state_cur.reset_counter != '0 && age < decay_lim) begin
                    state_next.reset_counter = state_cur.reset_counter - 1'b1;
                end
            end
        end
        result.reset_count = can_lrs_pkg::RCOUNT_W'(state_next.reset_counter);
    end

endmodule

FILE: design/can_link_recovery_supervisor.sv
// Top level of the CAN link recovery supervisor: config registers, word pipeline, state.
//
// Usage: each input word is a poll (s_tuser = 0) or the outcome of a reinit
// the block asked for (s_tuser = 1). Every input word yields exactly one
// result word on the m_ side: the action to take, the extra wait, the
// progressive reset count and the flags seen in the poll.
// A word taken lands in the input register, and its result is loaded into
// the output register once that register is empty or being taken. Throughput
// is one word per cycle while m_tready stays high; the reset counter and the
// last attempt time are read and updated in the single decision stage, so
// back to back words see each other's effects.
// The input register frees whenever the output register is empty or being
// taken, so a stall on m_tready holds one result and one waiting input word;
// s_tready drops only when both are full.
// Reset (aresetn low, synchronous) empties both stages, clears the reset
// counter and the last attempt time, and loads the default register values.
// Configuration writes (cfg_wr_en, cfg_index, cfg_wdata) take effect at the
// next edge and are meant for idle periods.
module can_link_recovery_supervisor (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // now_ms[31:0], last_rx_ms[63:32], error_flags[71:64], reinit_ok[72], zero fill
    input  logic [can_lrs_pkg::S_TDATA_W-1:0]   s_tdata,
    // mode[0]
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // action[2:0], wait_ms[16:3], reset_count[32:17], bus_off[33],
    // error_passive[34], rx_silent[35], zero fill
    output logic [can_lrs_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [can_lrs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [can_lrs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    can_lrs_pkg::cfg_t       cfg_reg, cfg_next;
    can_lrs_pkg::sup_state_t state_reg, state_next, state_calc;
    can_lrs_pkg::item_t      item_reg, item_next;
    can_lrs_pkg::result_t    res_reg, res_next, res_calc;
    logic                    in_valid_reg, in_valid_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    take_in;
    logic                    proc;

    assign proc     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || proc;
    assign take_in  = s_tvalid && s_tready;

    can_lrs_decide u_decide (
        .item      (item_reg),
        .cfg       (cfg_reg),
        .state_cur (state_reg),
        .state_next(state_calc),
        .result    (res_calc)
    );

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (can_lrs_pkg::cfg_index_t'(cfg_index))
                can_lrs_pkg::REG_POLL_PERIOD:
                    cfg_next.poll_interval_ms = cfg_wdata[can_lrs_pkg::POLL_W-1:0];
                can_lrs_pkg::REG_SILENCE:
                    cfg_next.silence_timeout_ms = cfg_wdata[can_lrs_pkg::SILENCE_W-1:0];
                can_lrs_pkg::REG_THRESH:
                    cfg_next.resets_before_backoff = cfg_wdata[can_lrs_pkg::THRESH_W-1:0];
                can_lrs_pkg::REG_STEP:
                    cfg_next.backoff_step_ms = cfg_wdata[can_lrs_pkg::STEP_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (take_in) begin
            in_valid_next = 1'b1;
        end else if (proc) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (proc) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
        state_next = proc ? state_calc : state_reg;
        res_next   = proc ? res_calc : res_reg;
        item_next  = item_reg;
        if (take_in) begin
            item_next.mode        = s_tuser;
            item_next.now_ms      = s_tdata[31:0];
            item_next.last_rx_ms  = s_tdata[63:32];
            item_next.error_flags = s_tdata[71:64];
            item_next.reinit_ok   = s_tdata[72];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
            cfg_reg.poll_interval_ms      <= can_lrs_pkg::POLL_PERIOD_RST;
            cfg_reg.silence_timeout_ms    <= can_lrs_pkg::SILENCE_RST;
            cfg_reg.resets_before_backoff <= can_lrs_pkg::THRESH_RST;
            cfg_reg.backoff_step_ms       <= can_lrs_pkg::STEP_RST;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
            cfg_reg       <= cfg_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        res_reg  <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = can_lrs_pkg::M_TDATA_W'({res_reg.rx_silent, res_reg.error_passive,
                                                res_reg.bus_off, res_reg.reset_count,
                                                res_reg.wait_ms, res_reg.action});

    // outcome words carry no poll flags
    a_outcome_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (res_reg.action == can_lrs_pkg::ACT_RECOVERED ||
                          res_reg.action == can_lrs_pkg::ACT_FAILED)
        |-> !res_reg.bus_off && !res_reg.error_passive && !res_reg.rx_silent)
        else $error("poll flags set on an outcome word");

    // only recovered/failed words carry a wait
    a_wait_only_outcome: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && res_reg.wait_ms != '0
        |-> res_reg.action == can_lrs_pkg::ACT_RECOVERED ||
            res_reg.action == can_lrs_pkg::ACT_FAILED)
        else $error("nonzero wait on a poll word");

    // state moves only when a word is processed
    a_state_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !proc |=> $stable(state_reg))
        else $error("supervisor state changed without a word");

    // attempt time is stamped only by a reinit request
    a_attempt_stamp: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && res_calc.action != can_lrs_pkg::ACT_REINIT
        |=> $stable(state_reg.last_attempt_ms))
        else $error("last attempt time moved without a reinit request");

endmodule

FILE: tb/can_link_recovery_supervisor_tb.sv
// Testbench for the CAN link recovery supervisor: directed and random words checked by a predictor.
`timescale 1ns / 1ps

module can_link_recovery_supervisor_tb;

    logic                                aclk;
    logic                                aresetn   = 1'b0;
    logic                                s_tvalid  = 1'b0;
    logic                                s_tready;
    logic [can_lrs_pkg::S_TDATA_W-1:0]   s_tdata   = '0;
    logic                                s_tuser   = 1'b0;
    logic                                m_tvalid;
    logic                                m_tready  = 1'b0;
    logic [can_lrs_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                                cfg_wr_en = 1'b0;
    logic [can_lrs_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [can_lrs_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

    // supervisor state and register copies kept by the predictor
    logic [can_lrs_pkg::COUNT_WIDTH-1:0] sup_count         = '0;
    logic [can_lrs_pkg::TIME_W-1:0]      last_reinit_ms    = '0;
    logic [can_lrs_pkg::POLL_W-1:0]      poll_period       = can_lrs_pkg::POLL_PERIOD_RST;
    logic [can_lrs_pkg::SILENCE_W-1:0]   silence_limit     = can_lrs_pkg::SILENCE_RST;
    logic [can_lrs_pkg::THRESH_W-1:0]    backoff_threshold = can_lrs_pkg::THRESH_RST;
    logic [can_lrs_pkg::STEP_W-1:0]      backoff_step      = can_lrs_pkg::STEP_RST;

    can_lrs_pkg::result_t expected_results[$];
    int                   mismatch_count = 0;
    int                   words_sent     = 0;
    int                   stall_left     = 0;
    bit                   free_run       = 1'b0;

    can_link_recovery_supervisor i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("can_link_recovery_supervisor_tb failed");
        $finish;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) < 16) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic can_lrs_pkg::result_t decide_action(can_lrs_pkg::item_t w);
        can_lrs_pkg::result_t           r;
        logic [can_lrs_pkg::TIME_W-1:0] age;
        logic [can_lrs_pkg::TIME_W-1:0] since_try;
        longint unsigned                backoff;
        r         = '0;
        age       = w.now_ms - w.last_rx_ms;
        since_try = w.now_ms - last_reinit_ms;
        if (w.mode) begin
            if (w.reinit_ok) begin
                if (sup_count != '1) sup_count++;
                r.action = can_lrs_pkg::ACT_RECOVERED;
                if (sup_count >= backoff_threshold) begin
                    backoff = longint'(backoff_step) *
                              (longint'(sup_count) - longint'(backoff_threshold) + 1);
                    r.wait_ms = (backoff > can_lrs_pkg::BACKOFF_CAP)
                                ? can_lrs_pkg::BACKOFF_CAP
                                : backoff[can_lrs_pkg::WAIT_W-1:0];
                end
            end else begin
                r.action  = can_lrs_pkg::ACT_FAILED;
                r.wait_ms = can_lrs_pkg::FAIL_WAIT;
            end
        end else begin
            r.bus_off       = |(w.error_flags & can_lrs_pkg::FLAG_BUS_OFF);
            r.error_passive = |(w.error_flags & can_lrs_pkg::FLAG_ERR_PASS);
            r.rx_silent     = (w.last_rx_ms != '0) ? (age > silence_limit)
                                                   : (w.now_ms > silence_limit);
            if (|(w.error_flags & can_lrs_pkg::FLAG_OVERFLOW)) begin
                r.action = can_lrs_pkg::ACT_CLEAR_OVF;
            end else if (r.bus_off || r.error_passive || r.rx_silent) begin
                if (since_try < poll_period) begin
                    r.action = can_lrs_pkg::ACT_HELD_OFF;
                end else begin
                    r.action       = can_lrs_pkg::ACT_REINIT;
                    last_reinit_ms = w.now_ms;
                end
            end else begin
                r.action = can_lrs_pkg::ACT_HEALTHY;
                if (sup_count != '0 && age < (silence_limit >> can_lrs_pkg::DECAY_SHIFT))
                    sup_count--;
            end
        end
        r.reset_count = sup_count[can_lrs_pkg::RCOUNT_W-1:0];
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // bus monitor: checks result words, predicts accepted input words, tracks registers
    always @(posedge aclk) begin
        can_lrs_pkg::result_t want;
        can_lrs_pkg::item_t   w;
        if (!aresetn) begin
            sup_count         = '0;
            last_reinit_ms    = '0;
            poll_period       = can_lrs_pkg::POLL_PERIOD_RST;
            silence_limit     = can_lrs_pkg::SILENCE_RST;
            backoff_threshold = can_lrs_pkg::THRESH_RST;
            backoff_step      = can_lrs_pkg::STEP_RST;
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result word with no expectation pending");
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("action", want.action, m_tdata[2:0]);
                    check_field("wait_ms", want.wait_ms, m_tdata[16:3]);
                    check_field("reset_count", want.reset_count, m_tdata[32:17]);
                    check_field("bus_off", want.bus_off, m_tdata[33]);
                    check_field("error_passive", want.error_passive, m_tdata[34]);
                    check_field("rx_silent", want.rx_silent, m_tdata[35]);
                end
            end
            if (s_tvalid && s_tready) begin
                w.mode        = s_tuser;
                w.now_ms      = s_tdata[31:0];
                w.last_rx_ms  = s_tdata[63:32];
                w.error_flags = s_tdata[71:64];
                w.reinit_ok   = s_tdata[72];
                expected_results.push_back(decide_action(w));
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    can_lrs_pkg::REG_POLL_PERIOD:
                        poll_period = cfg_wdata[can_lrs_pkg::POLL_W-1:0];
                    can_lrs_pkg::REG_SILENCE:
                        silence_limit = cfg_wdata[can_lrs_pkg::SILENCE_W-1:0];
                    can_lrs_pkg::REG_THRESH:
                        backoff_threshold = cfg_wdata[can_lrs_pkg::THRESH_W-1:0];
                    can_lrs_pkg::REG_STEP:
                        backoff_step = cfg_wdata[can_lrs_pkg::STEP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // result side backpressure
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (!free_run && $urandom_range(0, 3) == 0) begin
            m_tready <= 1'b0;
            stall_left = gap_len() - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_word(logic mode, logic [can_lrs_pkg::TIME_W-1:0] now,
                             logic [can_lrs_pkg::TIME_W-1:0] last_rx,
                             logic [can_lrs_pkg::FLAGS_W-1:0] flags, logic ok);
        int   gap;
        logic ready_seen;
        gap = (!free_run && $urandom_range(0, 2) == 0) ? gap_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {7'b0, ok, flags, last_rx, now};
        do begin
            @(negedge aclk);
            ready_seen = s_tready;
            @(posedge aclk);
        end while (!ready_seen);
        words_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(can_lrs_pkg::cfg_index_t idx, int unsigned value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= can_lrs_pkg::CFG_DATA_W'(value);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic randomize_registers();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        write_reg(can_lrs_pkg::REG_POLL_PERIOD,
                  (pick == 0) ? 0 : (pick == 1) ? 65535 : $urandom_range(1, 500));
        pick = $urandom_range(0, 19);
        write_reg(can_lrs_pkg::REG_SILENCE, (pick < 2) ? 0 : (pick < 4) ? 3600000 :
                  (pick == 4) ? 4194303 : $urandom_range(1, 5000));
        pick = $urandom_range(0, 9);
        write_reg(can_lrs_pkg::REG_THRESH, (pick == 0) ? 255 : $urandom_range(0, 6));
        pick = $urandom_range(0, 19);
        write_reg(can_lrs_pkg::REG_STEP, (pick < 2) ? 15000 : (pick == 2) ? 16383 :
                  (pick < 5) ? 0 : $urandom_range(0, 3000));
    endtask

    // default registers: overflow priority, silence, hold-off spacing
    task automatic test_poll_decisions();
        send_word(1'b0, 0, 0, 8'h00, 1'b0);
        send_word(1'b0, 2001, 0, 8'h00, 1'b0);
        send_word(1'b0, 2050, 2040, can_lrs_pkg::FLAG_BUS_OFF, 1'b0);
        send_word(1'b0, 2100, 2090, can_lrs_pkg::FLAG_ERR_PASS, 1'b1);
        send_word(1'b0, 2101, 2090, can_lrs_pkg::FLAG_ERR_PASS, 1'b0);
        send_word(1'b0, 5000, 3000, 8'h0F, 1'b0);
        send_word(1'b0, 5101, 3100, 8'h00, 1'b0);
        send_word(1'b0, 5150, 5140, 8'h40, 1'b0);
        send_word(1'b0, 5160, 5150, 8'hB0, 1'b0);
        send_word(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1);
        send_word(1'b0, 0, 32'hFFFF_FFFF, 8'h0F, 1'b0);
    endtask

    // failure wait, backoff growth, decay on healthy traffic
    task automatic test_reinit_outcomes();
        send_word(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b0);
        repeat (4) send_word(1'b1, 0, 0, 8'h00, 1'b1);
        send_word(1'b0, 100000, 99500, 8'h00, 1'b0);
        send_word(1'b0, 100000, 99000, 8'h00, 1'b0);
        send_word(1'b0, 50, 0, 8'h00, 1'b0);
    endtask

    task automatic test_register_extremes();
        wait_drained();
        write_reg(can_lrs_pkg::REG_POLL_PERIOD, 0);
        write_reg(can_lrs_pkg::REG_SILENCE, 0);
        write_reg(can_lrs_pkg::REG_THRESH, 0);
        write_reg(can_lrs_pkg::REG_STEP, 16383);
        send_word(1'b0, 1, 0, 8'h00, 1'b0);
        send_word(1'b0, 1, 1, 8'h00, 1'b0);
        send_word(1'b1, 0, 0, 8'h00, 1'b1);
        wait_drained();
        write_reg(can_lrs_pkg::REG_POLL_PERIOD, 65535);
        write_reg(can_lrs_pkg::REG_SILENCE, 4194303);
        write_reg(can_lrs_pkg::REG_THRESH, 255);
        write_reg(can_lrs_pkg::REG_STEP, 0);
        send_word(1'b0, 70000, 65000, can_lrs_pkg::FLAG_BUS_OFF, 1'b0);
        send_word(1'b0, 70000 + 65534, 70000, can_lrs_pkg::FLAG_ERR_PASS, 1'b0);
        send_word(1'b1, 0, 0, 8'h00, 1'b1);
    endtask

    task automatic test_random_traffic();
        logic [can_lrs_pkg::TIME_W-1:0]  clock_ms;
        logic [can_lrs_pkg::TIME_W-1:0]  last_rx;
        logic [can_lrs_pkg::TIME_W-1:0]  age;
        logic [can_lrs_pkg::FLAGS_W-1:0] flags;
        int unsigned                     pick;
        int                              seg_end;
        clock_ms = $urandom;
        for (int seg = 0; seg < 6; seg++) begin
            wait_drained();
            randomize_registers();
            free_run = (seg == 2 || seg == 5);
            seg_end  = words_sent + 65;
            while (words_sent < seg_end) begin
                pick = $urandom_range(0, 99);
                if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
                else clock_ms += $urandom_range(0, 2 * poll_period + 1);
                if (pick < 35) begin
                    // healthy poll, age sometimes right at the decay boundary
                    if ($urandom_range(0, 3) == 0)
                        age = (silence_limit >> 1) - $urandom_range(0, 1);
                    else
                        age = $urandom_range(0, silence_limit);
                    send_word(1'b0, clock_ms, clock_ms - age, 8'($urandom_range(0, 15)),
                              1'($urandom));
                end else if (pick < 60) begin
                    flags = 8'($urandom_range(0, 63));
                    case ($urandom_range(0, 2))
                        0:       flags |= can_lrs_pkg::FLAG_BUS_OFF;
                        1:       flags |= can_lrs_pkg::FLAG_ERR_PASS;
                        default: ;
                    endcase
                    last_rx = ($urandom_range(0, 3) == 0) ? '0 :
                              clock_ms - silence_limit - $urandom_range(0, 3);
                    send_word(1'b0, clock_ms, last_rx, flags, 1'($urandom));
                    if ($urandom_range(0, 3) != 0)
                        send_word(1'b1, $urandom, $urandom, 8'($urandom),
                                  $urandom_range(0, 4) != 0);
                end else if (pick < 70) begin
                    flags = 8'($urandom);
                    if (!(|(flags & can_lrs_pkg::FLAG_OVERFLOW)))
                        flags |= 8'h40 << $urandom_range(0, 1);
                    send_word(1'b0, clock_ms, $urandom, flags, 1'($urandom));
                end else if (pick < 80) begin
                    // fault right at the end of the hold-off window
                    clock_ms = last_reinit_ms + poll_period - $urandom_range(0, 1);
                    send_word(1'b0, clock_ms, clock_ms - $urandom_range(0, 3),
                              ($urandom_range(0, 1) != 0) ? can_lrs_pkg::FLAG_BUS_OFF
                                                          : can_lrs_pkg::FLAG_ERR_PASS,
                              1'b0);
                end else if (pick < 90) begin
                    send_word(1'($urandom), $urandom, $urandom, 8'($urandom), 1'($urandom));
                end else if (pick < 97) begin
                    send_word(1'b1, $urandom, $urandom, 8'($urandom), 1'($urandom));
                end else begin
                    wait_drained();
                end
            end
        end
        free_run = 1'b0;
    endtask

    // back to back successes drive the backoff into its cap
    task automatic test_backoff_cap();
        wait_drained();
        write_reg(can_lrs_pkg::REG_THRESH, 0);
        write_reg(can_lrs_pkg::REG_STEP, 1000);
        write_reg(can_lrs_pkg::REG_SILENCE, 2000);
        free_run = 1'b1;
        repeat (20) send_word(1'b1, $urandom, $urandom, 8'($urandom), 1'b1);
        free_run = 1'b0;
        send_word(1'b1, 0, 0, 8'h00, 1'b0);
        send_word(1'b0, 3000, 2990, 8'h00, 1'b0);
        send_word(1'b1, 0, 0, 8'h00, 1'b1);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_poll_decisions();
        test_reinit_outcomes();
        test_register_extremes();
        test_random_traffic();
        test_backoff_cap();
        wait_drained();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("can_link_recovery_supervisor_tb passed");
        else
            $display("can_link_recovery_supervisor_tb failed");
        $finish;
    end

endmodule

FILE: files.f
design/can_lrs_pkg.sv
design/can_lrs_decide.sv
design/can_link_recovery_supervisor.sv
tb/can_link_recovery_supervisor_tb.sv
